### sv/literal_text_match_scanner_top_defines.svh
// Assertion helpers used by the checker module ltms_chk.
`ifndef LITERAL_TEXT_MATCH_SCANNER_TOP_DEFINES_SVH
`define LITERAL_TEXT_MATCH_SCANNER_TOP_DEFINES_SVH

// Checked at every clock edge outside reset.
`define LTMS_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define LTMS_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

### sv/ltms_pkg.sv
package ltms_pkg;

   localparam int CHAR_W     = 8;
   localparam int PAT_BYTES  = 16;
   localparam int PB_W       = $clog2(PAT_BYTES);
   localparam int LEN_W      = 5;
   localparam int JDX_W      = 7;
   localparam int LINE_OUT_W = 20;
   localparam int COL_OUT_W  = 16;
   localparam int CSR_DATA_W = 64;
   localparam int CSR_ADDR_W = 3;
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 48;
   localparam int RSP_PAD_W  = RSP_DATA_W - LINE_OUT_W - COL_OUT_W - LEN_W;

   localparam logic [CSR_ADDR_W-1:0] REG_PAT_LO  = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_PAT_HI  = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_PAT_LEN = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_CASE    = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] REG_WORD    = 3'd4;

   localparam logic CMD_EOL = 1'b1;

   localparam logic [CHAR_W-1:0] CHR_UNDERSCORE = 8'h5F;
   localparam logic [CHAR_W-1:0] CHR_DIGIT_LO   = 8'h30;
   localparam logic [CHAR_W-1:0] CHR_DIGIT_HI   = 8'h39;
   localparam logic [CHAR_W-1:0] CHR_UPPER_LO   = 8'h41;
   localparam logic [CHAR_W-1:0] CHR_UPPER_HI   = 8'h5A;
   localparam logic [CHAR_W-1:0] CHR_LOWER_LO   = 8'h61;
   localparam logic [CHAR_W-1:0] CHR_LOWER_HI   = 8'h7A;
   localparam logic [CHAR_W-1:0] CASE_OFFSET    = 8'h20;

   typedef struct packed {
      logic [PAT_BYTES-1:0][CHAR_W-1:0] pat;
      logic [LEN_W-1:0]                 len;
      logic                             fold_en;
   } cfg_type;

   typedef struct packed {
      logic [LEN_W-1:0]      len;
      logic [COL_OUT_W-1:0]  column;
      logic [LINE_OUT_W-1:0] line;
   } rsp_type;

   function automatic logic is_word(input logic [CHAR_W-1:0] c);
      return (c >= CHR_DIGIT_LO && c <= CHR_DIGIT_HI) ||
             (c >= CHR_UPPER_LO && c <= CHR_UPPER_HI) ||
             (c >= CHR_LOWER_LO && c <= CHR_LOWER_HI) ||
             (c == CHR_UNDERSCORE);
   endfunction

   function automatic logic [CHAR_W-1:0] fold(input logic [CHAR_W-1:0] c,
                                              input logic fold_en);
      if (fold_en && c >= CHR_UPPER_LO && c <= CHR_UPPER_HI) begin
         return c + CASE_OFFSET;
      end
      return c;
   endfunction

endpackage

### sv/ltms_cell.sv
module ltms_cell #(
   parameter int IDX = 0
) (
   input  logic                        clock,
   input  logic                        shift_en,
   input  logic [ltms_pkg::CHAR_W-1:0] prev_byte,
   input  ltms_pkg::cfg_type           cfg,
   output logic [ltms_pkg::CHAR_W-1:0] cell_byte,
   output logic                        cmp_ok,
   output logic                        prev_word
);

   localparam int JW = ltms_pkg::JDX_W;
   localparam int PW = ltms_pkg::PB_W;

   logic [ltms_pkg::CHAR_W-1:0] byte_ff;
   logic [ltms_pkg::CHAR_W-1:0] byte_in;
   logic [JW-1:0]               len_w;
   logic [JW-1:0]               jdx;
   logic [ltms_pkg::CHAR_W-1:0] pat_byte;

   assign byte_in = shift_en ? prev_byte : byte_ff;

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
   end

   // this cell lines up with pattern byte len-1-IDX once the new byte is in
   always_comb begin
      len_w    = JW'(cfg.len);
      jdx      = len_w - JW'(IDX) - JW'(1);
      pat_byte = '0;
      if (jdx < JW'(ltms_pkg::PAT_BYTES)) begin
         pat_byte = cfg.pat[jdx[PW-1:0]];
      end
      cmp_ok = (len_w <= JW'(IDX)) ||
               (ltms_pkg::fold(prev_byte, cfg.fold_en) ==
                ltms_pkg::fold(pat_byte, cfg.fold_en));
   end

   assign prev_word = ltms_pkg::is_word(prev_byte);
   assign cell_byte = byte_ff;

endmodule

### sv/literal_text_match_scanner_top.sv
// Latency: a match is decided on the request after its last byte (or the end of line),
// and appears on rsp_* in the cycle after that request is taken if no older result waits.
// Throughput: one request per cycle; a two-entry result queue lets requests flow while
// a result waits, and req_tready drops only when both entries are held.
// Reset (synchronous): counters, pending match and queue clear, registers take their
// reset values; the byte window needs no clearing, so requests are taken at once.
module literal_text_match_scanner_top #(
   parameter int MAX_PATTERN = 16,
   parameter int COLUMN_BITS = 16,
   parameter int LINE_BITS   = 20
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [ltms_pkg::REQ_DATA_W-1:0]   req_tdata,  // [7:0] char_byte
   input  logic                              req_tuser,  // [0] cmd
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [ltms_pkg::RSP_DATA_W-1:0]   rsp_tdata,  // match_line, match_column, match_length
   input  logic                              csr_we,
   input  logic [ltms_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  logic [ltms_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int DEPTH = MAX_PATTERN + 1;
   localparam int CW    = COLUMN_BITS;
   localparam logic [CW-1:0]        COL_MAX  = '1;
   localparam logic [LINE_BITS-1:0] LINE_MAX = '1;

   typedef enum logic [1:0] {OCC_EMPTY, OCC_ONE, OCC_TWO} occ_type;

   logic [ltms_pkg::CSR_DATA_W-1:0] pat_lo_ff;
   logic [ltms_pkg::CSR_DATA_W-1:0] pat_hi_ff;
   logic [ltms_pkg::LEN_W-1:0]      len_ff;
   logic                            case_ff;
   logic                            word_ff;

   logic [CW-1:0]        col_ff;
   logic [CW-1:0]        resume_ff;
   logic [CW-1:0]        pend_col_ff;
   logic                 pend_ff;
   logic [LINE_BITS-1:0] line_ff;

   occ_type              occ_ff;
   ltms_pkg::rsp_type    head_ff;
   ltms_pkg::rsp_type    tail_ff;

   ltms_pkg::cfg_type    cfg;
   ltms_pkg::rsp_type    rsp_new;
   logic [DEPTH-1:0][ltms_pkg::CHAR_W-1:0] chain_in;
   logic [DEPTH-1:0][ltms_pkg::CHAR_W-1:0] cell_q;
   logic [DEPTH-1:0]     cmp_vec;
   logic [DEPTH-1:0]     word_vec;

   logic                 req_acc;
   logic                 eol;
   logic                 shift_en;
   logic                 push;
   logic                 pop;
   logic                 hit;
   logic                 cand;
   logic                 right_ok;
   logic                 len_ok;
   logic                 left_same;
   logic                 csr_hit;
   logic [CW:0]          col_p1;
   logic [CW:0]          len_ext;
   logic [CW:0]          start_ext;
   logic [CW:0]          resume_sum;
   logic [CW-1:0]        start;
   logic [CW-1:0]        resume_now;

   assign cfg.pat     = {pat_hi_ff, pat_lo_ff};
   assign cfg.len     = len_ff;
   assign cfg.fold_en = !case_ff;

   assign req_tready = (occ_ff != OCC_TWO);
   assign req_acc    = req_tvalid && req_tready;
   assign eol        = (req_tuser == ltms_pkg::CMD_EOL);
   assign shift_en   = req_acc && !eol;

   for (genvar k = 0; k < DEPTH; k++) begin : g_cell
      if (k == 0) begin : g_head
         assign chain_in[k] = req_tdata[ltms_pkg::CHAR_W-1:0];
      end else begin : g_link
         assign chain_in[k] = cell_q[k-1];
      end
      ltms_cell #(.IDX(k)) u_cell (
         .clock     (clock),
         .shift_en  (shift_en),
         .prev_byte (chain_in[k]),
         .cfg       (cfg),
         .cell_byte (cell_q[k]),
         .cmp_ok    (cmp_vec[k]),
         .prev_word (word_vec[k])
      );
   end

   always_comb begin
      len_ok    = (len_ff != '0) && (int'(len_ff) <= MAX_PATTERN);
      len_ext   = (CW+1)'(len_ff);
      col_p1    = {1'b0, col_ff} + (CW+1)'(1);
      right_ok  = !word_ff || (ltms_pkg::is_word(cell_q[0]) != word_vec[0]);
      hit       = pend_ff && (eol || right_ok);

      resume_sum = {1'b0, pend_col_ff} + len_ext;
      resume_now = resume_ff;
      if (hit) begin
         resume_now = resume_sum[CW] ? COL_MAX : resume_sum[CW-1:0];
      end

      start_ext = col_p1 - len_ext;
      start     = start_ext[CW-1:0];

      left_same = 1'b0;
      for (int k = 1; k < DEPTH; k++) begin
         if (int'(len_ff) == k) begin
            left_same = (word_vec[k] == word_vec[k-1]);
         end
      end

      cand = len_ok && (col_ff != COL_MAX) && (col_p1 >= len_ext) &&
             (start >= resume_now) && (&cmp_vec) &&
             !(word_ff && (start != '0) && left_same);

      rsp_new.line   = ltms_pkg::LINE_OUT_W'(line_ff);
      rsp_new.column = ltms_pkg::COL_OUT_W'(pend_col_ff);
      rsp_new.len    = len_ff;
   end

   assign csr_hit = csr_we && (csr_addr == ltms_pkg::REG_PAT_LO ||
                               csr_addr == ltms_pkg::REG_PAT_HI ||
                               csr_addr == ltms_pkg::REG_PAT_LEN ||
                               csr_addr == ltms_pkg::REG_CASE ||
                               csr_addr == ltms_pkg::REG_WORD);

   always_ff @(posedge clock) begin
      if (reset) begin
         pat_lo_ff <= '0;
         pat_hi_ff <= '0;
         len_ff    <= '0;
         case_ff   <= 1'b1;
         word_ff   <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_addr)
            ltms_pkg::REG_PAT_LO:  pat_lo_ff <= csr_wdata;
            ltms_pkg::REG_PAT_HI:  pat_hi_ff <= csr_wdata;
            ltms_pkg::REG_PAT_LEN: len_ff    <= csr_wdata[ltms_pkg::LEN_W-1:0];
            ltms_pkg::REG_CASE:    case_ff   <= csr_wdata[0];
            ltms_pkg::REG_WORD:    word_ff   <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff    <= '0;
         resume_ff <= '0;
         pend_ff   <= 1'b0;
         line_ff   <= '0;
      end else if (req_acc) begin
         if (eol) begin
            pend_ff   <= 1'b0;
            col_ff    <= '0;
            resume_ff <= '0;
            if (line_ff != LINE_MAX) begin
               line_ff <= line_ff + 1'b1;
            end
         end else begin
            pend_ff   <= cand;
            resume_ff <= resume_now;
            if (col_ff != COL_MAX) begin
               col_ff <= col_ff + 1'b1;
            end
         end
      end else if (csr_hit) begin
         pend_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc && !eol && cand) begin
         pend_col_ff <= start;
      end
   end

   assign push = req_acc && hit;
   assign pop  = rsp_tvalid && rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= OCC_EMPTY;
      end else begin
         unique case (occ_ff)
            OCC_EMPTY: begin
               if (push) begin
                  head_ff <= rsp_new;
                  occ_ff  <= OCC_ONE;
               end
            end
            OCC_ONE: begin
               priority if (push && pop) begin
                  head_ff <= rsp_new;
               end else if (push) begin
                  tail_ff <= rsp_new;
                  occ_ff  <= OCC_TWO;
               end else if (pop) begin
                  occ_ff  <= OCC_EMPTY;
               end else begin
                  occ_ff  <= OCC_ONE;
               end
            end
            OCC_TWO: begin
               if (pop) begin
                  head_ff <= tail_ff;
                  occ_ff  <= OCC_ONE;
               end
            end
            default: occ_ff <= OCC_EMPTY;
         endcase
      end
   end

   assign rsp_tvalid = (occ_ff != OCC_EMPTY);
   assign rsp_tdata  = {{ltms_pkg::RSP_PAD_W{1'b0}}, head_ff};

endmodule

### sv/ltms_chk.sv
`include "literal_text_match_scanner_top_defines.svh"

module ltms_chk (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [ltms_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   localparam int LEN_LO = ltms_pkg::LINE_OUT_W + ltms_pkg::COL_OUT_W;
   localparam int LEN_HI = LEN_LO + ltms_pkg::LEN_W - 1;

   logic                       req_acc;
   logic                       rsp_stall;
   logic [ltms_pkg::LEN_W-1:0] rsp_len;

   assign req_acc   = req_tvalid && req_tready;
   assign rsp_stall = rsp_tvalid && !rsp_tready;
   assign rsp_len   = rsp_tdata[LEN_HI:LEN_LO];

   `LTMS_ASSERT(a_rsp_hold, rsp_stall |=> rsp_tvalid && $stable(rsp_tdata), "result moved")
   `LTMS_ASSERT(a_len_nonzero, rsp_tvalid |-> rsp_len != '0, "result with zero length")
   `LTMS_ASSERT_ALWAYS(a_reset_empty, $past(reset) |-> !rsp_tvalid, "result after reset")
   `LTMS_ASSERT(a_rsp_cause, $rose(rsp_tvalid) |-> $past(req_acc), "result without request")
   `LTMS_ASSERT(a_stall_cause, !req_tready |-> rsp_tvalid, "stall with nothing waiting")

endmodule

bind literal_text_match_scanner_top ltms_chk u_ltms_chk (.*);

### tb/sv/literal_text_match_scanner_top_tb.sv
`timescale 1ns / 100ps

module literal_text_match_scanner_top_tb;

   localparam logic                            CMD_CHAR  = 1'b0;
   localparam logic [ltms_pkg::CSR_ADDR_W-1:0] REG_SPARE = 3'd7;
   localparam int unsigned COL_TOP   = (1 << ltms_pkg::COL_OUT_W) - 1;
   localparam int unsigned LINE_TOP  = (1 << ltms_pkg::LINE_OUT_W) - 1;
   localparam int          WIN_LEN   = ltms_pkg::PAT_BYTES + 1;
   localparam int          LAT_WAIT  = 4;
   localparam int          WATCHDOG  = 1000;

   typedef logic [ltms_pkg::CHAR_W-1:0] octet_type;
   typedef octet_type pat_bytes_type [ltms_pkg::PAT_BYTES];

   typedef struct {
      logic [ltms_pkg::LINE_OUT_W-1:0] line;
      logic [ltms_pkg::COL_OUT_W-1:0]  column;
      logic [ltms_pkg::LEN_W-1:0]      length;
   } hit_type;

   logic                            clock = 1'b0;
   logic                            reset;
   logic                            req_tvalid;
   logic                            req_tready;
   logic [ltms_pkg::REQ_DATA_W-1:0] req_tdata;
   logic                            req_tuser;
   logic                            rsp_tvalid;
   logic                            rsp_tready;
   logic [ltms_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                            csr_we;
   logic [ltms_pkg::CSR_ADDR_W-1:0] csr_addr;
   logic [ltms_pkg::CSR_DATA_W-1:0] csr_wdata;

   // scanner copy: configuration
   logic [63:0]    pat_lo;
   logic [63:0]    pat_hi;
   logic [ltms_pkg::LEN_W-1:0] pat_len;
   logic           exact;
   logic           whole;
   // scanner copy: state
   octet_type      recent [WIN_LEN];
   int unsigned    col_n;
   int unsigned    line_n;
   logic           pend_v;
   int unsigned    pend_col;
   int unsigned    resume_col;

   hit_type        hits_due [$];
   int             mismatches;
   int             rsp_hold;
   int             quiet_cycles;
   logic           calm;

   literal_text_match_scanner_top u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic word_char(input octet_type c);
      return (c >= ltms_pkg::CHR_DIGIT_LO && c <= ltms_pkg::CHR_DIGIT_HI) ||
             (c >= ltms_pkg::CHR_UPPER_LO && c <= ltms_pkg::CHR_UPPER_HI) ||
             (c >= ltms_pkg::CHR_LOWER_LO && c <= ltms_pkg::CHR_LOWER_HI) ||
             (c == ltms_pkg::CHR_UNDERSCORE);
   endfunction

   function automatic octet_type case_norm(input octet_type c);
      if (!exact && c >= ltms_pkg::CHR_UPPER_LO && c <= ltms_pkg::CHR_UPPER_HI) begin
         return c + ltms_pkg::CASE_OFFSET;
      end
      return c;
   endfunction

   function automatic octet_type pat_at(input int unsigned j);
      if (j < 8) begin
         return pat_lo[8*j +: 8];
      end
      if (j < 16) begin
         return pat_hi[8*(j-8) +: 8];
      end
      return '0;
   endfunction

   function automatic void log_hit(input int unsigned at);
      hit_type h;
      h.line   = ltms_pkg::LINE_OUT_W'(line_n);
      h.column = ltms_pkg::COL_OUT_W'(at);
      h.length = pat_len;
      hits_due = {hits_due, h};
      resume_col = at + pat_len;
      if (resume_col > COL_TOP) begin
         resume_col = COL_TOP;
      end
   endfunction

   function automatic void scan_item(input logic cmd, input octet_type c);
      int unsigned st;
      int unsigned j;
      logic        ok;
      if (cmd == ltms_pkg::CMD_EOL) begin
         if (pend_v) begin
            log_hit(pend_col);
         end
         pend_v     = 1'b0;
         col_n      = 0;
         resume_col = 0;
         if (line_n < LINE_TOP) begin
            line_n++;
         end
         return;
      end
      if (pend_v) begin
         if (!whole || word_char(recent[0]) != word_char(c)) begin
            log_hit(pend_col);
         end
         pend_v = 1'b0;
      end
      for (int k = WIN_LEN - 1; k > 0; k--) begin
         recent[k] = recent[k-1];
      end
      recent[0] = c;
      if (pat_len != 0 && pat_len <= ltms_pkg::PAT_BYTES && col_n < COL_TOP &&
          col_n + 1 >= pat_len) begin
         st = col_n + 1 - pat_len;
         ok = (st >= resume_col);
         for (j = 0; ok && j < pat_len; j++) begin
            if (case_norm(recent[pat_len-1-j]) != case_norm(pat_at(j))) begin
               ok = 1'b0;
            end
         end
         if (ok && whole && st != 0 &&
             word_char(recent[pat_len]) == word_char(recent[pat_len-1])) begin
            ok = 1'b0;
         end
         if (ok) begin
            pend_v   = 1'b1;
            pend_col = st;
         end
      end
      if (col_n < COL_TOP) begin
         col_n++;
      end
   endfunction

   function automatic void cfg_apply(input logic [ltms_pkg::CSR_ADDR_W-1:0] addr,
                                     input logic [ltms_pkg::CSR_DATA_W-1:0] data);
      case (addr)
         ltms_pkg::REG_PAT_LO:  pat_lo  = data;
         ltms_pkg::REG_PAT_HI:  pat_hi  = data;
         ltms_pkg::REG_PAT_LEN: pat_len = data[ltms_pkg::LEN_W-1:0];
         ltms_pkg::REG_CASE:    exact   = data[0];
         ltms_pkg::REG_WORD:    whole   = data[0];
         default:               return;
      endcase
      pend_v = 1'b0;
   endfunction

   function automatic pat_bytes_type pat_from(input string s);
      pat_bytes_type p;
      foreach (p[i]) begin
         p[i] = (i < s.len()) ? octet_type'(s[i]) : '0;
      end
      return p;
   endfunction

   task automatic send_item(input logic cmd, input octet_type c);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 8);
      @(negedge clock);
      repeat (gap) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= c;
      do @(posedge clock); while (!req_tready);
      scan_item(cmd, c);
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) begin
         send_item(CMD_CHAR, s[i]);
      end
   endtask

   task automatic send_eol;
      send_item(ltms_pkg::CMD_EOL, octet_type'($urandom_range(0, 255)));
   endtask

   // stop requests and let every predicted match drain out
   task automatic settle;
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (hits_due.size() != 0) @(posedge clock);
      repeat (LAT_WAIT) @(posedge clock);
   endtask

   task automatic cfg_write(input logic [ltms_pkg::CSR_ADDR_W-1:0] addr,
                            input logic [ltms_pkg::CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= data;
      @(posedge clock);
      cfg_apply(addr, data);
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic load_config(input pat_bytes_type p, input int len, input logic ex,
                              input logic wh);
      logic [63:0] lo;
      logic [63:0] hi;
      logic [63:0] w;
      settle;
      for (int i = 0; i < 8; i++) begin
         lo[8*i +: 8] = p[i];
         hi[8*i +: 8] = p[i+8];
      end
      cfg_write(ltms_pkg::REG_PAT_LO, lo);
      cfg_write(ltms_pkg::REG_PAT_HI, hi);
      w = {$urandom, $urandom};
      w[ltms_pkg::LEN_W-1:0] = ltms_pkg::LEN_W'(len);
      cfg_write(ltms_pkg::REG_PAT_LEN, w);
      w = {$urandom, $urandom};
      w[0] = ex;
      cfg_write(ltms_pkg::REG_CASE, w);
      w = {$urandom, $urandom};
      w[0] = wh;
      cfg_write(ltms_pkg::REG_WORD, w);
   endtask

   task automatic test_after_reset;
      send_text("ab");
      send_eol;
   endtask

   task automatic test_full_width;
      pat_bytes_type p;
      foreach (p[i]) begin
         p[i] = 8'hFF;
      end
      load_config(p, ltms_pkg::PAT_BYTES, 1'b1, 1'b0);
      repeat (ltms_pkg::PAT_BYTES) send_item(CMD_CHAR, 8'hFF);
      send_item(CMD_CHAR, 8'h00);
      send_eol;
   endtask

   task automatic test_case_and_word;
      load_config(pat_from("aB"), 2, 1'b0, 1'b1);
      send_text("Ab x_ab AB_ ab");
      send_eol;
   endtask

   task automatic test_no_overlap;
      load_config(pat_from("aa"), 2, 1'b1, 1'b0);
      send_text("aaaaa");
      send_eol;
   endtask

   task automatic test_bad_length;
      load_config(pat_from("aa"), 0, 1'b1, 1'b0);
      send_text("aa");
      send_eol;
      load_config(pat_from("aa"), ltms_pkg::PAT_BYTES + 1, 1'b1, 1'b0);
      send_text("aa");
      send_eol;
      load_config(pat_from("aa"), 31, 1'b1, 1'b0);
      send_text("aa");
      send_eol;
   endtask

   task automatic test_write_drops_pending;
      load_config(pat_from("zz"), 2, 1'b1, 1'b0);
      send_text("zz");
      settle;
      cfg_write(REG_SPARE, {$urandom, $urandom});
      send_text("qzz");
      settle;
      cfg_write(ltms_pkg::REG_WORD, '0);
      send_text("q");
      send_eol;
   endtask

   task automatic test_random_phases;
      pat_bytes_type p;
      string      alph;
      int         len;
      int         n;
      int         r;
      int         cut;
      logic       ex;
      logic       wh;
      logic       pressed;
      octet_type  b;
      alph    = "aAbB_09 .zZ";
      pressed = 1'b0;
      for (int ph = 0; ph < 6; ph++) begin
         foreach (p[i]) begin
            p[i] = ($urandom_range(0, 7) == 0) ? octet_type'($urandom_range(0, 255))
                                               : octet_type'(alph[$urandom_range(0, alph.len()-1)]);
         end
         if (ph == 0) begin
            len = 1;  ex = 1'b1; wh = 1'b0;
         end else if (ph == 1) begin
            len = ltms_pkg::PAT_BYTES; ex = 1'b0; wh = 1'b1;
         end else begin
            r  = $urandom_range(0, 9);
            ex = 1'($urandom_range(0, 1));
            wh = 1'($urandom_range(0, 1));
            if (r == 0) begin
               len = 0;
            end else if (r == 1) begin
               len = $urandom_range(ltms_pkg::PAT_BYTES + 1, 31);
            end else if (r <= 5) begin
               len = $urandom_range(1, 4);
            end else begin
               len = $urandom_range(5, ltms_pkg::PAT_BYTES);
            end
         end
         load_config(p, len, ex, wh);
         calm = (ph == 2) ? 1'b1 : (ph == 5) ? 1'b0 : ($urandom_range(0, 3) == 0);
         n = 0;
         while (n < 165) begin
            if (ph == 3 && n >= 90 && !pressed) begin
               settle;
               pressed = 1'b1;
            end
            r = $urandom_range(0, 15);
            if (r == 0) begin
               send_eol;
               n++;
            end else if (r <= 7 && len >= 1 && len <= ltms_pkg::PAT_BYTES) begin
               // mostly whole copies, sometimes a cut-off prefix
               cut = ($urandom_range(0, 5) == 0) ? $urandom_range(1, len) : len;
               for (int j = 0; j < cut; j++) begin
                  b = p[j];
                  if (!ex && $urandom_range(0, 1) &&
                      ((b >= ltms_pkg::CHR_UPPER_LO && b <= ltms_pkg::CHR_UPPER_HI) ||
                       (b >= ltms_pkg::CHR_LOWER_LO && b <= ltms_pkg::CHR_LOWER_HI))) begin
                     b = b ^ ltms_pkg::CASE_OFFSET;
                  end
                  send_item(CMD_CHAR, b);
               end
               n += cut;
            end else begin
               b = ($urandom_range(0, 3) == 0) ? octet_type'($urandom_range(0, 255))
                                               : octet_type'(alph[$urandom_range(0, alph.len()-1)]);
               send_item(CMD_CHAR, b);
               n++;
            end
         end
      end
      calm = 1'b0;
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = 1'b0;
      csr_we     = 1'b0;
      csr_addr   = '0;
      csr_wdata  = '0;
      calm       = 1'b0;
      mismatches = 0;
      pat_lo     = '0;
      pat_hi     = '0;
      pat_len    = '0;
      exact      = 1'b1;
      whole      = 1'b0;
      foreach (recent[i]) begin
         recent[i] = '0;
      end
      col_n      = 0;
      line_n     = 0;
      pend_v     = 1'b0;
      pend_col   = 0;
      resume_col = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_after_reset;
      test_full_width;
      test_case_and_word;
      test_no_overlap;
      test_bad_length;
      test_write_drops_pending;
      test_random_phases;

      settle;
      repeat (8) @(posedge clock);
      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin
      rsp_hold   = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold != 0) begin
            rsp_tready <= 1'b0;
            rsp_hold--;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin : check_hits
      hit_type                         want;
      logic [ltms_pkg::LINE_OUT_W-1:0] got_line;
      logic [ltms_pkg::COL_OUT_W-1:0]  got_col;
      logic [ltms_pkg::LEN_W-1:0]      got_len;
      got_line = rsp_tdata[ltms_pkg::LINE_OUT_W-1:0];
      got_col  = rsp_tdata[ltms_pkg::LINE_OUT_W +: ltms_pkg::COL_OUT_W];
      got_len  = rsp_tdata[ltms_pkg::LINE_OUT_W + ltms_pkg::COL_OUT_W +: ltms_pkg::LEN_W];
      if (!reset && rsp_tvalid && rsp_tready) begin
         rsp_hold = calm ? 0 : $urandom_range(0, 8);
         if (hits_due.size() == 0) begin
            $display("%0t: match with none expected: line %0d column %0d length %0d",
                     $time, got_line, got_col, got_len);
            mismatches++;
         end else begin
            want = hits_due.pop_front();
            if (got_line != want.line) begin
               $display("%0t: match_line expected %0d actual %0d", $time, want.line, got_line);
               mismatches++;
            end
            if (got_col != want.column) begin
               $display("%0t: match_column expected %0d actual %0d",
                        $time, want.column, got_col);
               mismatches++;
            end
            if (got_len != want.length) begin
               $display("%0t: match_length expected %0d actual %0d",
                        $time, want.length, got_len);
               mismatches++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG) begin
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

endmodule

### filelist.f
+incdir+sv
sv/ltms_pkg.sv
sv/ltms_cell.sv
sv/literal_text_match_scanner_top.sv
sv/ltms_chk.sv
tb/sv/literal_text_match_scanner_top_tb.sv
